// ----- src/assert_macros.svh -----
// Assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge once reset is released
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition holds whenever a word is shown on the output
`define ASSERT_ON_RESULT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		result_valid |-> (cond)) else $error(msg);

`endif

// ----- src/csvfs_pkg.sv -----
package csvfs_pkg;

	localparam int unsigned MAX_FIELDS = 255;
	localparam int unsigned FIELD_CAP_INT = (MAX_FIELDS < 255) ? MAX_FIELDS : 255;
	localparam logic [7:0] FIELD_CAP = FIELD_CAP_INT[7:0];

	localparam logic [7:0] SEPARATOR_RESET = 8'd44;
	localparam logic [7:0] QUOTE_RESET = 8'd34;

	// Most result words one input byte can cause
	localparam int unsigned BUNDLE_MAX = 3;

	typedef enum logic {
		REG_SEPARATOR = 1'b0,
		REG_QUOTE     = 1'b1
	} reg_index_t;

	typedef enum logic [1:0] {
		KIND_DATA    = 2'd0,
		KIND_END     = 2'd1,
		KIND_ABANDON = 2'd2,
		KIND_STATUS  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_TRAIL_SEP = 2'd1,
		STATUS_BAD_COUNT = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_record;
	} item_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] out_byte;
		status_t    status;
		logic [7:0] field_total;
		logic       last_of_run;
	} result_t;

	// Result words of one input byte, slot 0 goes out first
	typedef struct packed {
		result_t [BUNDLE_MAX-1:0] slot;
		logic [1:0]               count;
	} bundle_t;

	function automatic logic [7:0] sat_inc(input logic [7:0] value);
		logic [7:0] res;
		res = (value < FIELD_CAP) ? value + 8'd1 : value;
		return res;
	endfunction

	function automatic result_t make_result(input kind_t kind, input logic [7:0] byte_val,
			input status_t status, input logic [7:0] total);
		result_t res;
		res.kind = kind;
		res.out_byte = byte_val;
		res.status = status;
		res.field_total = total;
		res.last_of_run = 1'b0;
		return res;
	endfunction

endpackage

// ----- src/csvfs_parse.sv -----
module csvfs_parse
	import csvfs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  reg_index_t cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       accept,
	input  item_t      item,
	output bundle_t    bundle
);

	logic [7:0] sep_q;
	logic [7:0] quote_q;
	logic       quote_open_q;
	logic       prior_quote_q;
	logic [7:0] fields_q;
	logic [7:0] expected_q;
	logic       known_q;

	logic       is_sep;
	logic       is_quote;
	logic       first_valid;
	result_t    first_res;
	logic       quote_mid;
	logic       prior_mid;
	logic [7:0] fields_mid;
	logic [7:0] fields_end;
	logic [7:0] expected_use;
	status_t    rec_status;
	result_t    close_res;
	result_t    stat_res;
	logic       quote_next;
	logic       prior_next;
	logic [7:0] fields_next;
	logic       learn;

	// Classify the byte and work out the result words
	always_comb begin
		is_sep = (item.data_byte == sep_q);
		is_quote = !is_sep && (item.data_byte == quote_q);
		first_valid = 1'b1;
		first_res = make_result(KIND_DATA, item.data_byte, STATUS_OK, 8'd0);
		quote_mid = quote_open_q;
		prior_mid = 1'b0;
		fields_mid = fields_q;
		if (is_sep) begin
			if (!quote_open_q) begin
				first_res = make_result(KIND_END, 8'd0, STATUS_OK, 8'd0);
				fields_mid = sat_inc(fields_q);
			end
		end else if (is_quote) begin
			quote_mid = !quote_open_q;
			prior_mid = 1'b1;
			// Pass a doubled quote on as one quote byte
			first_valid = !quote_open_q && prior_quote_q;
		end

		// Close or abandon the open field at record end
		if (quote_mid) begin
			close_res = make_result(KIND_ABANDON, 8'd0, STATUS_OK, 8'd0);
			fields_end = fields_mid;
		end else begin
			close_res = make_result(KIND_END, 8'd0, STATUS_OK, 8'd0);
			fields_end = sat_inc(fields_mid);
		end
		learn = !is_sep && !known_q;
		expected_use = known_q ? expected_q : fields_end;
		if (is_sep) begin
			rec_status = STATUS_TRAIL_SEP;
		end else if (expected_use != 8'd0 && expected_use == fields_end) begin
			rec_status = STATUS_OK;
		end else begin
			rec_status = STATUS_BAD_COUNT;
		end
		stat_res = make_result(KIND_STATUS, 8'd0, rec_status, fields_end);
		stat_res.last_of_run = 1'b1;

		if (item.end_of_record) begin
			quote_next = 1'b0;
			prior_next = 1'b0;
			fields_next = 8'd0;
		end else begin
			quote_next = quote_mid;
			prior_next = prior_mid;
			fields_next = fields_mid;
		end
	end

	// Pack the result words in order of delivery
	always_comb begin
		bundle.slot = '0;
		bundle.count = 2'd0;
		if (item.end_of_record) begin
			if (first_valid) begin
				bundle.slot[0] = first_res;
				bundle.slot[1] = close_res;
				bundle.slot[2] = stat_res;
				bundle.count = 2'd3;
			end else begin
				bundle.slot[0] = close_res;
				bundle.slot[1] = stat_res;
				bundle.count = 2'd2;
			end
		end else if (first_valid) begin
			bundle.slot[0] = first_res;
			bundle.slot[0].last_of_run = 1'b1;
			bundle.count = 2'd1;
		end
	end

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q <= SEPARATOR_RESET;
			quote_q <= QUOTE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SEPARATOR: sep_q <= cfg_data;
				REG_QUOTE:     quote_q <= cfg_data;
				default:       sep_q <= sep_q;
			endcase
		end
	end

	// Advance parser state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_open_q <= 1'b0;
			prior_quote_q <= 1'b0;
			fields_q <= 8'd0;
			expected_q <= 8'd0;
			known_q <= 1'b0;
		end else if (accept) begin
			quote_open_q <= quote_next;
			prior_quote_q <= prior_next;
			fields_q <= fields_next;
			if (item.end_of_record && learn) begin
				expected_q <= fields_end;
				known_q <= 1'b1;
			end
		end
	end

endmodule

// ----- src/csvfs_drain.sv -----
module csvfs_drain
	import csvfs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  bundle_t bundle,
	output logic    free,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	result_t [BUNDLE_MAX-1:0] slot_s1;
	logic [1:0]               count_s1;
	logic                     valid_q;
	result_t                  result_q;
	logic                     move;

	// Move the next pending word into the output register when it is free
	assign move = (count_s1 != 2'd0) && (!valid_q || result_ready);
	assign free = (count_s1 == 2'd0) || (count_s1 == 2'd1 && move);

	// Hold pending words, shift one out per move
	always_ff @(posedge clk) begin
		if (load) begin
			slot_s1 <= bundle.slot;
		end else if (move) begin
			slot_s1[0] <= slot_s1[1];
			slot_s1[1] <= slot_s1[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_s1 <= 2'd0;
		end else if (load) begin
			count_s1 <= bundle.count;
		end else if (move) begin
			count_s1 <= count_s1 - 2'd1;
		end
	end

	// Hold the output word until it is taken
	always_ff @(posedge clk) begin
		if (move) begin
			result_q <= slot_s1[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (move) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	assign result_valid = valid_q;
	assign result = result_q;

endmodule

// ----- src/csv_field_splitter.sv -----
// Each result word passes through the pending buffer and then the output register.
// Throughput: one byte per cycle while each byte gives at most one word and result_ready
// stays high; a record end gives two or three words, and the single output register sends
// one word per cycle while result_ready is high. Reset (arst_n low) clears quote parity,
// the field count and the learned count, and sets the separator to comma and the quote to double quote.
module csv_field_splitter
	import csvfs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       item_valid,
	output logic       item_ready,
	input  item_t      item,
	output logic       result_valid,
	input  logic       result_ready,
	output result_t    result
);

	bundle_t bundle;
	logic    accept;
	logic    free;

	// Take a word whenever the pending buffer is empty or its last word moves out this cycle
	assign item_ready = free;
	assign accept = item_valid && free;

	csvfs_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (reg_index_t'(cfg_index)),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.item      (item),
		.bundle    (bundle)
	);

	csvfs_drain u_drain (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (accept),
		.bundle       (bundle),
		.free         (free),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ----- src/csvfs_checker.sv -----
`include "assert_macros.svh"

module csvfs_checker
	import csvfs_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result
);

	// Stalled output word must hold
	`ASSERT_CLK(a_result_hold,
		result_valid && !result_ready |=> result_valid && $stable(result),
		"stalled result word changed")
	// Record status always closes the run of its byte
	`ASSERT_ON_RESULT(a_status_last,
		result.kind != KIND_STATUS || result.last_of_run,
		"status word not last of run")
	// Only data words carry a byte
	`ASSERT_ON_RESULT(a_byte_zero,
		result.kind == KIND_DATA || result.out_byte == 8'd0,
		"non-data word carries a byte")
	// Only status words carry status and total
	`ASSERT_ON_RESULT(a_status_zero,
		result.kind == KIND_STATUS ||
		(result.status == STATUS_OK && result.field_total == 8'd0),
		"non-status word carries status")
	// Status code stays in its range
	`ASSERT_ON_RESULT(a_status_range, result.status != 2'd3, "status code out of range")

endmodule

bind csv_field_splitter csvfs_checker u_csvfs_checker (.*);

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import csvfs_pkg::*;

	// Predicts the words of each accepted byte and checks them in order
	class splitter_scoreboard;
		logic [7:0] sep_char;
		logic [7:0] quote_byte;
		bit         in_quotes;
		bit         after_quote;
		logic [7:0] rec_fields;
		logic [7:0] learned_count;
		bit         count_learned;
		result_t    expected_q[$];
		int         mismatches;

		function new();
			sep_char = SEPARATOR_RESET;
			quote_byte = QUOTE_RESET;
			in_quotes = 1'b0;
			after_quote = 1'b0;
			rec_fields = 8'd0;
			learned_count = 8'd0;
			count_learned = 1'b0;
			mismatches = 0;
		endfunction

		function void set_register(reg_index_t idx, logic [7:0] value);
			if (idx == REG_SEPARATOR) begin
				sep_char = value;
			end else begin
				quote_byte = value;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function result_t word(kind_t k, logic [7:0] b, status_t s, logic [7:0] total);
			result_t r;
			r.kind = k;
			r.out_byte = b;
			r.status = s;
			r.field_total = total;
			r.last_of_run = 1'b0;
			return r;
		endfunction

		function void bump_count();
			if (rec_fields < FIELD_CAP) begin
				rec_fields = rec_fields + 8'd1;
			end
		endfunction

		// Work out the words caused by one accepted byte
		function void note_word(item_t w);
			result_t batch[3];
			int      n;
			bit      is_sep;
			status_t st;
			n = 0;
			is_sep = (w.data_byte == sep_char);
			if (is_sep) begin
				if (in_quotes) begin
					batch[n] = word(KIND_DATA, w.data_byte, STATUS_OK, 8'd0);
					n++;
				end else begin
					batch[n] = word(KIND_END, 8'd0, STATUS_OK, 8'd0);
					n++;
					bump_count();
				end
				after_quote = 1'b0;
			end else if (w.data_byte == quote_byte) begin
				in_quotes = !in_quotes;
				// a doubled quote gives one quote byte
				if (in_quotes && after_quote) begin
					batch[n] = word(KIND_DATA, w.data_byte, STATUS_OK, 8'd0);
					n++;
				end
				after_quote = 1'b1;
			end else begin
				batch[n] = word(KIND_DATA, w.data_byte, STATUS_OK, 8'd0);
				n++;
				after_quote = 1'b0;
			end

			// close the record: last field, then status
			if (w.end_of_record) begin
				if (in_quotes) begin
					batch[n] = word(KIND_ABANDON, 8'd0, STATUS_OK, 8'd0);
					n++;
				end else begin
					batch[n] = word(KIND_END, 8'd0, STATUS_OK, 8'd0);
					n++;
					bump_count();
				end
				if (is_sep) begin
					st = STATUS_TRAIL_SEP;
				end else begin
					if (!count_learned) begin
						learned_count = rec_fields;
						count_learned = 1'b1;
					end
					st = (learned_count != 8'd0 && learned_count == rec_fields) ?
						STATUS_OK : STATUS_BAD_COUNT;
				end
				batch[n] = word(KIND_STATUS, 8'd0, st, rec_fields);
				n++;
				in_quotes = 1'b0;
				after_quote = 1'b0;
				rec_fields = 8'd0;
			end

			if (n > 0) begin
				batch[n-1].last_of_run = 1'b1;
			end
			for (int i = 0; i < n; i++) begin
				expected_q = {expected_q, batch[i]};
			end
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			mismatches++;
		endtask

		// Compare one output word with the oldest expectation
		task check_word(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("word kind %0d with nothing expected", got.kind));
			end else begin
				want = expected_q.pop_front();
				if (got.kind !== want.kind)
					report($sformatf("kind got %0d want %0d", got.kind, want.kind));
				if (got.out_byte !== want.out_byte)
					report($sformatf("out_byte got %0h want %0h", got.out_byte, want.out_byte));
				if (got.status !== want.status)
					report($sformatf("status got %0d want %0d", got.status, want.status));
				if (got.field_total !== want.field_total)
					report($sformatf("field_total got %0d want %0d",
						got.field_total, want.field_total));
				if (got.last_of_run !== want.last_of_run)
					report($sformatf("last_of_run got %0b want %0b",
						got.last_of_run, want.last_of_run));
			end
		endtask
	endclass

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS = 228;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_index;
	logic [7:0] cfg_data;
	logic       item_valid;
	logic       item_ready;
	item_t      item;
	logic       result_valid;
	logic       result_ready;
	result_t    result;

	splitter_scoreboard sb;
	logic [7:0] rec_bytes[$];
	bit         steady;
	int         hold_ticket;
	int         items_sent;
	int         cycle_count;

	csv_field_splitter uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Stop a hung run
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Receiver: check words, stall at random, hold off on request
	initial begin
		int seen_ticket;
		int hold_left;
		seen_ticket = 0;
		hold_left = 0;
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && result_ready) begin
				sb.check_word(result);
			end
			if (hold_ticket != seen_ticket) begin
				seen_ticket = hold_ticket;
				hold_left = 90;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= steady || ($urandom_range(99) >= 30);
			end
		end
	end

	task automatic send_word(input item_t w);
		// idle at random before offering the word
		if (!steady && $urandom_range(99) < 30) begin
			item_valid <= 1'b0;
			do @(posedge clk); while (!steady && $urandom_range(99) < 30);
		end
		item_valid <= 1'b1;
		item <= w;
		do @(posedge clk); while (!item_ready);
		sb.note_word(w);
		items_sent++;
	endtask

	task automatic send_record();
		item_t w;
		for (int i = 0; i < rec_bytes.size(); i++) begin
			w.data_byte = rec_bytes[i];
			w.end_of_record = (i == rec_bytes.size() - 1);
			send_word(w);
		end
	endtask

	task automatic send_text(input string s);
		rec_bytes.delete();
		for (int i = 0; i < s.len(); i++) begin
			rec_bytes = {rec_bytes, s[i]};
		end
		send_record();
	endtask

	// Wait out every expected word, then let a dropped quote settle
	task automatic drain();
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_setting(input logic [7:0] sep, input logic [7:0] quote);
		item_valid <= 1'b0;
		drain();
		cfg_we <= 1'b1;
		cfg_index <= REG_SEPARATOR;
		cfg_data <= sep;
		@(posedge clk);
		cfg_index <= REG_QUOTE;
		cfg_data <= quote;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_register(REG_SEPARATOR, sep);
		sb.set_register(REG_QUOTE, quote);
	endtask

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(255)); while (b == sb.sep_char || b == sb.quote_byte);
		return b;
	endfunction

	// Build a record: mostly well-formed fields, sometimes raw noise
	function automatic void make_record();
		int nf;
		int len;
		int pick;
		rec_bytes.delete();
		if ($urandom_range(99) < 75) begin
			nf = ($urandom_range(99) < 70) ? 3 : $urandom_range(1, 5);
			for (int f = 0; f < nf; f++) begin
				if (f > 0) rec_bytes = {rec_bytes, sb.sep_char};
				pick = $urandom_range(2);
				if (pick == 0) begin
					len = $urandom_range(1, 5);
					repeat (len) rec_bytes = {rec_bytes, plain_byte()};
				end else if (pick == 1) begin
					rec_bytes = {rec_bytes, sb.quote_byte};
					len = $urandom_range(5);
					repeat (len) begin
						pick = $urandom_range(99);
						if (pick < 15) begin
							rec_bytes = {rec_bytes, sb.sep_char};
						end else if (pick < 30) begin
							rec_bytes = {rec_bytes, sb.quote_byte};
							rec_bytes = {rec_bytes, sb.quote_byte};
						end else begin
							rec_bytes = {rec_bytes, plain_byte()};
						end
					end
					rec_bytes = {rec_bytes, sb.quote_byte};
				end
			end
			if ($urandom_range(99) < 10) rec_bytes = {rec_bytes, sb.sep_char};
			if (rec_bytes.size() == 0) rec_bytes = {rec_bytes, plain_byte()};
		end else begin
			len = $urandom_range(1, 8);
			repeat (len) begin
				pick = $urandom_range(99);
				if (pick < 25) rec_bytes = {rec_bytes, sb.sep_char};
				else if (pick < 50) rec_bytes = {rec_bytes, sb.quote_byte};
				else rec_bytes = {rec_bytes, 8'($urandom_range(255))};
			end
		end
	endfunction

	initial begin
		int         phase_items;
		logic [7:0] v;
		sb = new();
		steady = 1'b0;
		hold_ticket = 0;
		items_sent = 0;
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_SEPARATOR;
		cfg_data <= 8'd0;
		item_valid <= 1'b0;
		item <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: learn three fields, quoted separator, doubled quote,
		// trailing separator, abandoned field, byte extremes, bad count
		send_text("a,b,c");
		send_text("\"s,\"\"t\",,");
		send_text("\"u");
		rec_bytes.delete();
		rec_bytes = {rec_bytes, 8'h00};
		rec_bytes = {rec_bytes, 8'h2c};
		rec_bytes = {rec_bytes, 8'hff};
		rec_bytes = {rec_bytes, 8'h2c};
		rec_bytes = {rec_bytes, 8'h7f};
		send_record();
		send_text("z");

		// Random phases over several settings
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: apply_setting(8'h00, 8'hff);
				1: apply_setting(8'hff, 8'h00);
				2: begin
					v = 8'($urandom_range(255));
					apply_setting(v, v);
				end
				3, 4: apply_setting(8'($urandom_range(255)), 8'($urandom_range(255)));
				default: apply_setting(SEPARATOR_RESET, QUOTE_RESET);
			endcase
			steady = (p == 3);
			// hold off the receiver while records keep coming
			if (p == 1) hold_ticket <= hold_ticket + 1;
			phase_items = 0;
			while (phase_items < RANDOM_ITEMS / 6) begin
				make_record();
				phase_items += rec_bytes.size();
				send_record();
			end
		end
		steady = 1'b0;
		item_valid <= 1'b0;

		drain();
		if (sb.mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
